### hw/rtl/tdpt_pkg.sv
// Shared constants for the trial-division prime test unit.
package tdpt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int WHEEL_FIRST    = 5;
  localparam int WHEEL_STEP     = 6;
  localparam int WHEEL_PAIR     = 2;
  localparam int SMALL_PRIME    = 3;

endpackage

### hw/rtl/trial_division_prime_test_unit.sv
// Trial-division (6k-1 / 6k+1) primality test with one shared serial divider.
//
//   channel | ports              | word contents
//   --------+--------------------+--------------------------------------
//   input   | in_tvalid/tready   | tdata: number (signed, DATA_WIDTH)
//   result  | out_tvalid/tready  | tdata: prime_flag (bit 0)
//
// Each remainder is worked out bit by bit in the restoring divider; each
// wheel pair costs one bound check plus two remainders.
// Negatives, 0..3 and even numbers skip the divider and go straight to ST_FIN.
// rst_n is synchronous and active low; it clears the sequencer and out_tvalid.
// in_tready is high only while the sequencer is idle; a waiting result
// does not block the next input word.
module trial_division_prime_test_unit #(
  parameter int DATA_WIDTH = tdpt_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,  // [DATA_WIDTH-1:0] number
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata  // [0] prime_flag
);
  import tdpt_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] n_r, n_nxt;
  logic [DATA_WIDTH-1:0] base_r, base_nxt;
  logic [DATA_WIDTH:0]   sq_r, sq_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  phase_r, phase_nxt;
  logic                  flag_r, flag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_flag_r, out_flag_nxt;

  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_step;
  logic [DATA_WIDTH-1:0] base_next;
  logic [DATA_WIDTH:0]   sq_inc;

  assign num      = in_tdata[DATA_WIDTH-1:0];
  assign rem_sh   = {rem_r, n_r[cnt_r]};
  assign diff     = rem_sh - {1'b0, div_r};
  assign rem_step = diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
  assign base_next = base_r + DATA_WIDTH'(WHEEL_STEP);
  // (b+6)^2 = b^2 + 12b + 36
  assign sq_inc   = ({1'b0, base_r} << 3) + ({1'b0, base_r} << 2)
                  + (DATA_WIDTH + 1)'(WHEEL_STEP * WHEEL_STEP);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_flag_r};

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    base_nxt      = base_r;
    sq_nxt        = sq_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_flag_nxt  = out_flag_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt     = num;
          div_nxt   = DATA_WIDTH'(SMALL_PRIME);
          rem_nxt   = '0;
          cnt_nxt   = CW'(DATA_WIDTH - 1);
          state_nxt = ST_FIN;
          if (num[DATA_WIDTH-1] || num <= DATA_WIDTH'(1)) begin
            flag_nxt = 1'b0;
          end else if (num <= DATA_WIDTH'(SMALL_PRIME)) begin
            flag_nxt = 1'b1;
          end else if (!num[0]) begin
            flag_nxt = 1'b0;
          end else begin
            state_nxt = ST_DIV3;
          end
        end
      end
      ST_DIV3: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (rem_step == '0) begin
            flag_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            base_nxt  = DATA_WIDTH'(WHEEL_FIRST);
            sq_nxt    = (DATA_WIDTH + 1)'(WHEEL_FIRST * WHEEL_FIRST);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        rem_nxt   = '0;
        cnt_nxt   = CW'(DATA_WIDTH - 1);
        div_nxt   = base_r;
        phase_nxt = 1'b0;
        if (sq_r > {1'b0, n_r}) begin
          flag_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rem_nxt = '0;
          cnt_nxt = CW'(DATA_WIDTH - 1);
          if (rem_step == '0) begin
            flag_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else if (!phase_r) begin
            phase_nxt = 1'b1;
            div_nxt   = base_r + DATA_WIDTH'(WHEEL_PAIR);
          end else begin
            base_nxt  = base_next;
            sq_nxt    = sq_r + sq_inc;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    base_r     <= base_nxt;
    sq_r       <= sq_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    phase_r    <= phase_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

endmodule

### bench/tb_trial_division_prime_test_unit.sv
// Stream testbench for the trial-division prime test unit: directed and random numbers.
module tb_trial_division_prime_test_unit;

  localparam int DW         = tdpt_pkg::DATA_WIDTH_DEF;
  localparam int TDATA_W    = ((DW + 7) / 8) * 8;
  localparam int IDLE_PCT   = 26;
  localparam int RAND_ITEMS = 100;
  localparam int STUCK_MAX  = 2000000;
  localparam int TAIL       = 50;

  typedef struct packed {
    logic [DW-1:0] number;
    bit            flag;
  } verdict_t;

  class prime_verdict_tracker;
    verdict_t    pending_verdicts[$];
    int unsigned mismatches;
    int unsigned numbers_seen;
    int unsigned negatives_seen;
    int unsigned primes_seen;

    // 6k-1 / 6k+1 wheel; bound kept as d <= n/d so it never wraps
    static function bit trial_division_flag(logic [DW-1:0] num);
      longint unsigned n;
      longint unsigned d;
      if (num[DW-1])
        return 1'b0;
      n = 64'(num);
      if (n <= 1)
        return 1'b0;
      if (n <= tdpt_pkg::SMALL_PRIME)
        return 1'b1;
      if (n % 2 == 0 || n % tdpt_pkg::SMALL_PRIME == 0)
        return 1'b0;
      for (d = tdpt_pkg::WHEEL_FIRST; d <= n / d; d += tdpt_pkg::WHEEL_STEP) begin
        if (n % d == 0 || n % (d + tdpt_pkg::WHEEL_PAIR) == 0)
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [DW-1:0] num);
      verdict_t v;
      v.number = num;
      v.flag   = trial_division_flag(num);
      pending_verdicts.push_back(v);
      numbers_seen++;
      if (num[DW-1])
        negatives_seen++;
      if (v.flag)
        primes_seen++;
    endfunction

    function void check_flag(bit actual);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("prime_flag: no word expected, actual %0b", actual);
        mismatches++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (v.flag !== actual) begin
        $error("prime_flag for %0d: expected %0b, actual %0b",
               $signed(v.number), v.flag, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;

  bit                 calm = 1'b0;
  int unsigned        stuck_cycles = 0;
  prime_verdict_tracker board = new();

  trial_division_prime_test_unit #(.DATA_WIDTH(DW)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (!rst_n)
      out_tready = 1'b0;
    else
      out_tready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_number(in_tdata[DW-1:0]);
      if (out_tvalid && out_tready)
        board.check_flag(out_tdata[0]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_MAX) begin
        $error("timeout: no word moved for %0d cycles", STUCK_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

  // called at a falling edge; leaves in_tvalid high after the word is taken
  task automatic send_number(input logic [DW-1:0] num);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = '0;
    in_tdata[DW-1:0] = num;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_verdicts();
    in_tvalid = 1'b0;
    while (board.pending_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // mostly small numbers so the divisor loop stays short; many are 6k+-1
  function automatic logic [DW-1:0] random_number();
    int unsigned   sel;
    int unsigned   bits;
    logic [63:0]   v;
    sel = $urandom_range(99);
    if (sel < 5)
      return DW'($urandom()) | (DW'(1) << (DW - 1));
    if (sel < 9)
      return DW'($urandom()) & ~(DW'(1) << (DW - 1));
    bits = (sel < 25) ? $urandom_range(20, 13) : $urandom_range(12, 2);
    v = 64'($urandom()) & ((64'd1 << bits) - 1);
    if (sel >= 35)
      v = (v / 6) * 6 + ($urandom_range(1) ? 1 : 5);
    return DW'(v);
  endfunction

  initial begin
    logic [DW-1:0] directed[$];
    directed = '{0, 1, 2, 3, 4, 5, 6, 9, 25, 35, 49, 121, 143, 289, 7919, 65521,
                 1000003, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9,
                 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF};
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_number(directed[i]);
    drain_verdicts();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 40 && i < 70);
      if (i == 20 || i == 80)
        drain_verdicts();
      send_number(random_number());
    end
    calm = 1'b0;
    drain_verdicts();
    repeat (TAIL) @(posedge clk);

    $display("covered %0d numbers (%0d negative, %0d prime), directed edges and random sizes",
             board.numbers_seen, board.negatives_seen, board.primes_seen);
    $display("both sides stalled at random, with one stall-free stretch and two drain pauses");
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
